[rtl/mid64_pkg.sv]
`default_nettype none

package mid64_pkg;

    // block and cell types
    typedef logic [63:0] t_block;
    typedef logic [3:0]  t_cell;

    // number of keyed rounds
    localparam int ROUNDS = 15;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    // Sb0 substitution box
    localparam t_cell SBOX [16] = '{
        4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
        4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
    };

    // ShuffleCell: cell i takes source cell SHUF_SRC[i]
    localparam t_cell SHUF_SRC [16] = '{
        4'd0, 4'd10, 4'd5, 4'd15, 4'd14, 4'd4, 4'd11, 4'd1,
        4'd9, 4'd3, 4'd12, 4'd6, 4'd7, 4'd13, 4'd2, 4'd8
    };

    // round constants, cell 0 in bit 15
    localparam logic [15:0] RC [ROUNDS] = '{
        16'h15B3, 16'h78C0, 16'hA435, 16'h6213, 16'h104F,
        16'hD170, 16'h0266, 16'h0BCC, 16'h9481, 16'h40B8,
        16'h7197, 16'h228E, 16'h5130, 16'hF8CA, 16'hDF90
    };

    // SubCell over all sixteen cells
    function automatic t_block f_sub(input t_block s);
        t_block o;
        for (int i = 0; i < 16; i++) begin
            o[63-4*i -: 4] = SBOX[s[63-4*i -: 4]];
        end
        return o;
    endfunction

    // ShuffleCell permutation
    function automatic t_block f_shuffle(input t_block s);
        t_block o;
        for (int i = 0; i < 16; i++) begin
            o[63-4*i -: 4] = s[63-4*int'(SHUF_SRC[i]) -: 4];
        end
        return o;
    endfunction

    // column mix: each cell becomes the XOR of the other three in its column
    function automatic t_block f_mix(input t_block s);
        t_block o;
        t_cell  all;
        for (int c = 0; c < 4; c++) begin
            all = s[63-16*c -: 4] ^ s[59-16*c -: 4] ^ s[55-16*c -: 4] ^ s[51-16*c -: 4];
            for (int r = 0; r < 4; r++) begin
                o[63-16*c-4*r -: 4] = all ^ s[63-16*c-4*r -: 4];
            end
        end
        return o;
    endfunction

    // spread a round constant into the cell LSBs
    function automatic t_block f_rc_word(input logic [15:0] rc);
        t_block o;
        o = '0;
        for (int i = 0; i < 16; i++) begin
            o[60-4*i] = rc[15-i];
        end
        return o;
    endfunction

    // one full keyed round
    function automatic t_block f_round(input t_block s, input t_block rk,
                                       input logic [15:0] rc);
        return f_mix(f_shuffle(f_sub(s))) ^ rk ^ f_rc_word(rc);
    endfunction

endpackage

`default_nettype wire

[rtl/mid64_front.sv]
`default_nettype none

module mid64_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire mid64_pkg::t_block i_plaintext,
    input  wire mid64_pkg::t_block i_wkey,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output mid64_pkg::t_block      o_data
);
    import mid64_pkg::*;

    logic   r_valid;
    t_block r_data;
    logic   accept;

    // hold the request only while the queue is full
    assign o_stall = r_valid & i_q_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_q_full;
    assign o_data  = r_data;

    // input register with whitening applied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_plaintext ^ i_wkey;
        end
    end

endmodule

`default_nettype wire

[rtl/mid64_queue.sv]
`default_nettype none

module mid64_queue #(
    parameter int DEPTH = mid64_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mid64_pkg::t_block i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output mid64_pkg::t_block      o_data
);
    import mid64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_block        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mid64_back.sv]
`default_nettype none

module mid64_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire mid64_pkg::t_block i_q_data,
    output logic                   o_pop,
    input  wire mid64_pkg::t_block i_key0,
    input  wire mid64_pkg::t_block i_key1,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mid64_pkg::t_block      o_ciphertext
);
    import mid64_pkg::*;

    logic [ROUNDS-1:0] r_vld;
    t_block            r_dat [ROUNDS];
    logic              r_out_valid;
    t_block            r_out;
    logic              adv;

    // whole pipe moves unless a finished result is held
    assign adv          = ~r_out_valid | ~i_stall;
    assign o_pop        = adv;
    assign o_valid      = r_out_valid;
    assign o_ciphertext = r_out;

    // first round takes from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dat[0] <= f_round(i_q_data, i_key0, RC[0]);
        end
    end

    // remaining rounds, key halves alternate
    for (genvar j = 1; j < ROUNDS; j++) begin : g_round
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (adv) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dat[j] <= f_round(r_dat[j-1], (j % 2 == 1) ? i_key1 : i_key0, RC[j]);
            end
        end
    end

    // final SubCell and whitening into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= f_sub(r_dat[ROUNDS-1]) ^ i_key0 ^ i_key1;
        end
    end

endmodule

`default_nettype wire

[rtl/midori64_block_encrypt_core.sv]
`default_nettype none

// channel     direction  handshake            payload
// plaintext   in         i_valid / o_stall    i_plaintext  [63:0]
// ciphertext  out        o_valid / i_stall    o_ciphertext [63:0]
// config      in         i_cfg_we             i_cfg_idx, i_cfg_data [63:0]
//
// One block is taken per cycle while the output is not stalled; the fifteen
// rounds are fully unrolled, one register stage per round.
// With an empty queue a result passes through the input register, the queue,
// the 15 rounds, then the final substitution as output register.
// Reset is synchronous, active low; both key halves clear to zero, no clearing pass.
// A stalled output freezes the round pipe; the front keeps taking requests
// until the queue fills.

module midori64_block_encrypt_core #(
    parameter int QUEUE_DEPTH = mid64_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire mid64_pkg::t_block              i_plaintext,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output mid64_pkg::t_block                   o_ciphertext,
    input  wire logic                           i_cfg_we,
    input  wire logic [mid64_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire mid64_pkg::t_block              i_cfg_data
);
    import mid64_pkg::*;

    t_block r_key0;
    t_block r_key1;
    logic   q_full;
    logic   q_push;
    t_block q_wdata;
    logic   q_valid;
    t_block q_rdata;
    logic   q_pop;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_LOW:  r_key0 <= i_cfg_data;
                REG_KEY_HIGH: r_key1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and whiten
    mid64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_plaintext(i_plaintext),
        .i_wkey     (r_key0 ^ r_key1),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_data     (q_wdata)
    );

    // queue between front and round pipe
    mid64_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_rdata)
    );

    // back: unrolled rounds
    mid64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_pop       (q_pop),
        .i_key0      (r_key0),
        .i_key1      (r_key1),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ciphertext(o_ciphertext)
    );

    // front only stalls on a full queue
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_full)
        else $error("front stalled with queue space free");

    // a push without a pop leaves the queue non-empty
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !(q_pop && q_valid)) |=> q_valid)
        else $error("queue lost a pushed request");

    // a held result is not dropped while stalled
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mid64_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_A_PHASE = 175;
    localparam int DRAIN_CYCLES  = 30;
    localparam int PRINT_CAP     = 40;

    // cipher tables, held locally for the predictor
    localparam logic [3:0] SB0 [16] = '{
        4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
        4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
    };
    localparam int CELL_FROM [16] = '{0, 10, 5, 15, 14, 4, 11, 1, 9, 3, 12, 6, 7, 13, 2, 8};
    // one word per round, cell 0 in bit 15
    localparam logic [15:0] ROUND_BITS [15] = '{
        16'h15B3, 16'h78C0, 16'hA435, 16'h6213, 16'h104F,
        16'hD170, 16'h0266, 16'h0BCC, 16'h9481, 16'h40B8,
        16'h7197, 16'h228E, 16'h5130, 16'hF8CA, 16'hDF90
    };

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    t_block               i_plaintext  = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    t_block               o_ciphertext;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = REG_KEY_LOW;
    t_block               i_cfg_data   = '0;

    // key copy held by the predictor
    t_block key_lo = '0;
    t_block key_hi = '0;

    t_block plain_pending [$];
    t_block cipher_due    [$];
    int     mismatches  = 0;
    int     cycle_count = 0;
    int     gap_left    = 0;
    int     stall_left  = 0;
    bit     quiet       = 1'b0;

    midori64_block_encrypt_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_plaintext  (i_plaintext),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ciphertext (o_ciphertext),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // SubCell over the whole block
    function automatic t_block sub_all(input t_block s);
        t_block o;
        for (int i = 0; i < 16; i++) begin
            o[63-4*i -: 4] = SB0[s[63-4*i -: 4]];
        end
        return o;
    endfunction

    // full Midori64 encryption of one block
    function automatic t_block midori_encrypt(input t_block pt, input t_block k0,
                                              input t_block k1);
        t_block     s;
        t_block     t;
        t_block     wk;
        logic [3:0] col;
        wk = k0 ^ k1;
        s  = pt ^ wk;
        for (int r = 0; r < 15; r++) begin
            s = sub_all(s);
            for (int i = 0; i < 16; i++) begin
                t[63-4*i -: 4] = s[63-4*CELL_FROM[i] -: 4];
            end
            // each cell takes the XOR of the other three in its column
            for (int c = 0; c < 4; c++) begin
                col = t[63-16*c -: 4] ^ t[59-16*c -: 4] ^ t[55-16*c -: 4] ^ t[51-16*c -: 4];
                for (int j = 0; j < 4; j++) begin
                    s[63-16*c-4*j -: 4] = col ^ t[63-16*c-4*j -: 4];
                end
            end
            s = s ^ ((r % 2) ? k1 : k0);
            for (int i = 0; i < 16; i++) begin
                s[60-4*i] = s[60-4*i] ^ ROUND_BITS[r][15-i];
            end
        end
        return sub_all(s) ^ wk;
    endfunction

    // mostly dense random blocks, some with a single bit set or clear, some repeated-nibble ones
    function automatic t_block rand_block();
        t_block     b;
        int         pick;
        logic [3:0] nib;
        pick = $urandom_range(0, 9);
        b    = {$urandom, $urandom};
        if (pick == 0) begin
            b = t_block'(1) << $urandom_range(0, 63);
        end else if (pick == 1) begin
            b = ~(t_block'(1) << $urandom_range(0, 63));
        end else if (pick == 2) begin
            nib = 4'($urandom_range(0, 15));
            b   = {16{nib}};
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input t_block got, input t_block want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch: %s got %h want %h (cycle %0d)", what, got, want, cycle_count);
        end
        mismatches++;
    endtask

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input t_block data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_KEY_LOW) begin
            key_lo = data;
        end else begin
            key_hi = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender idle and every ciphertext back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (plain_pending.size() != 0 || i_valid || cipher_due.size() != 0);
    endtask

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            plain_pending.push_back(rand_block());
        end
    endtask

    // request driver: predicts on acceptance, then loads the next block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                cipher_due.push_back(midori_encrypt(i_plaintext, key_lo, key_hi));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (plain_pending.size() != 0) begin
                    i_valid     <= 1'b1;
                    i_plaintext <= plain_pending.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_block want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (cipher_due.size() == 0) begin
                    report_mismatch("unexpected ciphertext", o_ciphertext, '0);
                end else begin
                    want = cipher_due.pop_front();
                    if (o_ciphertext !== want) begin
                        report_mismatch("ciphertext", o_ciphertext, want);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset keys: block extremes, single bits, patterns, every nibble value
        plain_pending.push_back(64'h0000_0000_0000_0000);
        plain_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        plain_pending.push_back(64'h8000_0000_0000_0000);
        plain_pending.push_back(64'h0000_0000_0000_0001);
        plain_pending.push_back(64'h5555_5555_5555_5555);
        plain_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        plain_pending.push_back(64'h0123_4567_89AB_CDEF);
        plain_pending.push_back(64'hFEDC_BA98_7654_3210);
        for (int v = 1; v < 15; v++) begin
            plain_pending.push_back({16{4'(v)}});
        end
        queue_random(ITEMS_A_PHASE - 22);
        wait_drained();

        // both halves at their top value
        write_key(REG_KEY_LOW, '1);
        write_key(REG_KEY_HIGH, '1);
        queue_random(ITEMS_A_PHASE);
        wait_drained();

        write_key(REG_KEY_LOW, '0);
        queue_random(ITEMS_A_PHASE);
        wait_drained();

        write_key(REG_KEY_LOW, '1);
        write_key(REG_KEY_HIGH, '0);
        queue_random(ITEMS_A_PHASE);
        wait_drained();

        // published key, with its known plaintext first
        write_key(REG_KEY_LOW, 64'h687D_ED3B_3C85_B3F3);
        write_key(REG_KEY_HIGH, 64'h5B10_0986_3E2A_8CBF);
        plain_pending.push_back(64'h42C2_0FD3_B586_879E);
        queue_random(ITEMS_A_PHASE - 1);
        wait_drained();

        // random keys
        for (int p = 0; p < 2; p++) begin
            write_key(REG_KEY_HIGH, {$urandom, $urandom});
            write_key(REG_KEY_LOW, {$urandom, $urandom});
            queue_random(ITEMS_A_PHASE);
            wait_drained();
        end

        // closing stretch at full rate, no idling either side
        write_key(REG_KEY_LOW, {$urandom, $urandom});
        write_key(REG_KEY_HIGH, {$urandom, $urandom});
        quiet = 1'b1;
        queue_random(ITEMS_A_PHASE);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
